FILE: rtl/fbc_pkg.sv
// shared types, constants and helpers for the frustum box containment block
package fbc_pkg;

   localparam int COORD_W     = 16;
   localparam int FIELD_W     = 16;
   localparam int PLANE_W     = 4 * FIELD_W;
   localparam int PLANE_COUNT = 6;
   localparam int REG_COUNT   = 6;
   localparam int CSR_IDX_W   = 3;
   localparam int PLANE_IDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
   localparam int D_SHIFT     = 8;
   localparam int PROD_W      = FIELD_W + COORD_W;
   localparam int SUM_W       = PROD_W + 2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [FIELD_W-1:0] field_type;
   typedef logic [PLANE_W-1:0]        plane_type;

   typedef enum logic [1:0] {
      RES_DISJOINT   = 2'd0,
      RES_INTERSECTS = 2'd1,
      RES_CONTAINS   = 2'd2
   } containment_type;

   typedef struct packed {
      coord_type min_x;
      coord_type min_y;
      coord_type min_z;
      coord_type max_x;
      coord_type max_y;
      coord_type max_z;
   } box_type;

   typedef struct packed {
      logic ld1;
      logic ld2;
      logic ld3;
   } stage_ctl_type;

   // slot 3 is normal x, slot 0 is offset d
   function automatic field_type plane_field(input plane_type plane, input logic [1:0] slot);
      field_type f;
      f = field_type'(plane >> (FIELD_W * int'(slot)));
      return f;
   endfunction

endpackage

FILE: rtl/fbc_if.sv
// valid/ready channel interfaces for box items, results and plane writes
interface fbc_req_if import fbc_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type box_min_x;
   coord_type box_min_y;
   coord_type box_min_z;
   coord_type box_max_x;
   coord_type box_max_y;
   coord_type box_max_z;

   modport source (output valid, box_min_x, box_min_y, box_min_z,
                   box_max_x, box_max_y, box_max_z, input ready);
   modport sink   (input valid, box_min_x, box_min_y, box_min_z,
                   box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface fbc_rsp_if import fbc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] containment;

   modport source (output valid, containment, input ready);
   modport sink   (input valid, containment, output ready);
endinterface

interface fbc_csr_if import fbc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   plane_type            data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/frustum_box_containment.sv
// top level of the frustum box containment classifier
//
//  channel  | dir | payload                               | handshake
//  req_ch   | in  | box_min_x/y/z, box_max_x/y/z (Q8.8)   | valid/ready
//  rsp_ch   | out | containment (0 disjoint, 1 inter, 2 in)| valid/ready
//  csr_ch   | in  | index 0..5, data (nx,ny,nz,d Q8.8)    | valid/ready
//
//  four register stages: vertex select, products, plane sums, classify
//  one item per cycle sustained while rsp_ch.ready is high; rsp valid once the classify stage is loaded
//  each stage holds on a stall only if the stage after it is full and held
//  synchronous reset clears the planes to zero and empties the pipeline
//  csr writes are always taken; index beyond five is dropped
module frustum_box_containment import fbc_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   fbc_req_if.sink   req_ch,
   fbc_rsp_if.source rsp_ch,
   fbc_csr_if.sink   csr_ch
);

   plane_type       plane_ff [PLANE_COUNT];
   logic            v1_ff, v2_ff, v3_ff, v4_ff;
   logic            v1_in, v2_in, v3_in, v4_in;
   logic            ld4;
   stage_ctl_type   ctl;
   box_type         box;
   logic [PLANE_COUNT-1:0] bpos;
   logic [PLANE_COUNT-1:0] bneg;
   containment_type res_in;
   containment_type res_ff;

   // plane registers
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PLANE_COUNT; i++) begin
            plane_ff[i] <= '0;
         end
      end else if (csr_ch.valid && int'(csr_ch.index) < REG_COUNT
                   && int'(csr_ch.index) < PLANE_COUNT) begin
         plane_ff[csr_ch.index[PLANE_IDX_W-1:0]] <= csr_ch.data;
      end
   end

   // stage load enables
   assign ld4     = !v4_ff || rsp_ch.ready;
   assign ctl.ld3 = !v3_ff || ld4;
   assign ctl.ld2 = !v2_ff || ctl.ld3;
   assign ctl.ld1 = !v1_ff || ctl.ld2;
   assign req_ch.ready = ctl.ld1;

   assign v1_in = ctl.ld1 ? req_ch.valid : v1_ff;
   assign v2_in = ctl.ld2 ? v1_ff : v2_ff;
   assign v3_in = ctl.ld3 ? v2_ff : v3_ff;
   assign v4_in = ld4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   assign box.min_x = req_ch.box_min_x;
   assign box.min_y = req_ch.box_min_y;
   assign box.min_z = req_ch.box_min_z;
   assign box.max_x = req_ch.box_max_x;
   assign box.max_y = req_ch.box_max_y;
   assign box.max_z = req_ch.box_max_z;

   for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_lane
      fbc_plane_lane u_lane (
         .clock      (clock),
         .ctl        (ctl),
         .plane      (plane_ff[i]),
         .box        (box),
         .behind_pos (bpos[i]),
         .behind_neg (bneg[i])
      );
   end

   // classify
   always_comb begin
      if (|bpos) begin
         res_in = RES_DISJOINT;
      end else if (|bneg) begin
         res_in = RES_INTERSECTS;
      end else begin
         res_in = RES_CONTAINS;
      end
   end

   always_ff @(posedge clock) begin
      if (ld4) begin
         res_ff <= res_in;
      end
   end

   assign rsp_ch.valid       = v4_ff;
   assign rsp_ch.containment = res_ff;

endmodule

FILE: rtl/fbc_plane_lane.sv
// one plane lane: vertex select, products, signed sum and behind flags
module fbc_plane_lane import fbc_pkg::*; (
   input  logic          clock,
   input  stage_ctl_type ctl,
   input  plane_type     plane,
   input  box_type       box,
   output logic          behind_pos,
   output logic          behind_neg
);

   field_type              nrm [3];
   field_type              d_val;
   coord_type              bmin [3];
   coord_type              bmax [3];
   coord_type              pv_in [3];
   coord_type              nv_in [3];
   coord_type              pv_ff [3];
   coord_type              nv_ff [3];
   logic signed [PROD_W-1:0] pp_in [3];
   logic signed [PROD_W-1:0] np_in [3];
   logic signed [PROD_W-1:0] pp_ff [3];
   logic signed [PROD_W-1:0] np_ff [3];
   logic signed [SUM_W-1:0]  d_ext;
   logic signed [SUM_W-1:0]  psum;
   logic signed [SUM_W-1:0]  nsum;
   logic                     bpos_ff;
   logic                     bneg_ff;

   assign nrm[0] = plane_field(plane, 2'd3);
   assign nrm[1] = plane_field(plane, 2'd2);
   assign nrm[2] = plane_field(plane, 2'd1);
   assign d_val  = plane_field(plane, 2'd0);

   assign bmin[0] = box.min_x;
   assign bmin[1] = box.min_y;
   assign bmin[2] = box.min_z;
   assign bmax[0] = box.max_x;
   assign bmax[1] = box.max_y;
   assign bmax[2] = box.max_z;

   // positive vertex takes max where the normal is non-negative
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         pv_in[a] = nrm[a][FIELD_W-1] ? bmin[a] : bmax[a];
         nv_in[a] = nrm[a][FIELD_W-1] ? bmax[a] : bmin[a];
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         pp_in[a] = PROD_W'(pv_ff[a]) * PROD_W'(nrm[a]);
         np_in[a] = PROD_W'(nv_ff[a]) * PROD_W'(nrm[a]);
      end
   end

   assign d_ext = SUM_W'(d_val) <<< D_SHIFT;
   assign psum  = SUM_W'(pp_ff[0]) + SUM_W'(pp_ff[1]) + SUM_W'(pp_ff[2]) + d_ext;
   assign nsum  = SUM_W'(np_ff[0]) + SUM_W'(np_ff[1]) + SUM_W'(np_ff[2]) + d_ext;

   always_ff @(posedge clock) begin
      if (ctl.ld1) begin
         pv_ff <= pv_in;
         nv_ff <= nv_in;
      end
      if (ctl.ld2) begin
         pp_ff <= pp_in;
         np_ff <= np_in;
      end
      if (ctl.ld3) begin
         bpos_ff <= psum[SUM_W-1];
         bneg_ff <= nsum[SUM_W-1];
      end
   end

   assign behind_pos = bpos_ff;
   assign behind_neg = bneg_ff;

endmodule

FILE: rtl/fbc_checker.sv
// port-level checks for the frustum box containment block, with bind
module fbc_checker import fbc_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] containment
);

   logic [2:0] cnt_ff;
   logic [2:0] cnt_in;
   logic       acc_in;
   logic       acc_out;

   assign acc_in  = req_valid && req_ready;
   assign acc_out = rsp_valid && rsp_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (acc_in && !acc_out) begin
         cnt_in = cnt_ff + 3'd1;
      end else if (!acc_in && acc_out) begin
         cnt_in = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(containment))
      else $error("result changed while stalled");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> containment != 2'd3)
      else $error("undefined containment code");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4)
      else $error("more items in flight than pipeline stages");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 3'd0 |-> !rsp_valid)
      else $error("result with no item in flight");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind frustum_box_containment fbc_checker u_fbc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .containment (rsp_ch.containment)
);
